### rtl/core/lctt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lctt_pkg: shared types and constants of the lazy-clear tagged table
// Field widths, operation codes and the command and status groups that
// join the controller and the datapath.
// ---------------------------------------------------------------------------
package lctt_pkg;

   localparam int MODE_W          = 2;
   localparam int KEY_W           = 11;
   localparam int CODE_W          = 31;
   localparam int COUNT_W         = 11;
   localparam int DEFAULT_ENTRIES = 1024;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  entry_index;
      logic [CODE_W-1:0] code_in;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [CODE_W-1:0]  code_out;
      logic [COUNT_W-1:0] live_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic clr_step;
      logic rd_slot;
      logic rd_stack;
      logic exec;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
   } ctl_sts_type;

endpackage
`default_nettype wire

### rtl/core/lctt_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lctt_ctrl: operation sequencer
// Runs the post-reset sweep of the slot array, then steps each transfer
// through the slot read, the stack read and the execute cycle.
// ---------------------------------------------------------------------------
module lctt_ctrl
   import lctt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire ctl_sts_type sts,
   output logic             busy,
   output ctl_cmd_type      cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SLOT  = 3'd2;
   localparam logic [2:0] ST_STACK = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   // A new transfer may be taken in the execute cycle of the previous one.
   assign busy   = !((state_ff == ST_IDLE) || (state_ff == ST_EXEC));
   assign accept = start && !busy;

   always_comb begin
      cmd          = '0;
      cmd.capture  = accept;
      state_in     = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            cmd.rd_slot = 1'b1;
            state_in    = ST_STACK;
         end
         ST_STACK: begin
            cmd.rd_stack = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = accept ? ST_SLOT : ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/lctt_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lctt_dpath: table storage and update logic
// Holds the slot array, the index stack, the code store, the stack top and
// the live count, and forms the result of each operation.
// ---------------------------------------------------------------------------
module lctt_dpath
   import lctt_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   input  wire ctl_cmd_type cmd,
   output ctl_sts_type      sts,
   output logic            rsp_strobe,
   output rsp_type          rsp_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam int KW = (IW > KEY_W) ? IW : KEY_W;
   localparam int TW = IW + 1;

   typedef struct packed {
      logic          erased;
      logic [IW-1:0] idx;
   } stack_word_type;

   logic [IW-1:0]  slot_mem  [ENTRIES];
   stack_word_type stack_mem [ENTRIES];
   logic [CODE_W-1:0] code_mem [ENTRIES];

   req_type           req_ff;
   logic [IW-1:0]     slot_rd_ff;
   stack_word_type    stack_rd_ff;
   logic [CODE_W-1:0] code_rd_ff;
   logic [TW-1:0]     top_ff;
   logic [TW-1:0]     top_in;
   logic [TW-1:0]     count_ff;
   logic [TW-1:0]     count_in;
   logic [IW-1:0]     clr_cnt_ff;
   logic              strobe_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [KW-1:0]  k_ext;
   logic [IW-1:0]  addr;
   logic           in_range;
   logic           live;
   logic           hit;
   logic           valid;
   logic           erased_hit;
   logic           can_push;

   logic           slot_we;
   logic [IW-1:0]  slot_wa;
   logic [IW-1:0]  slot_wd;
   logic           stack_we;
   logic [IW-1:0]  stack_wa;
   stack_word_type stack_wd;
   logic           code_we;

   assign k_ext    = KW'(req_ff.entry_index);
   assign addr     = k_ext[IW-1:0];
   assign in_range = {1'b0, k_ext} < (KW+1)'(ENTRIES);

   // A valid entry is in range, its slot points below the top, and the stack
   // cell there names it back unerased; any stale slot value fails this check.
   assign live       = {1'b0, slot_rd_ff} < top_ff;
   assign hit        = live && (stack_rd_ff.idx == addr);
   assign valid      = in_range && hit && !stack_rd_ff.erased;
   assign erased_hit = in_range && hit && stack_rd_ff.erased;
   assign can_push   = top_ff < TW'(ENTRIES);

   assign sts.clr_last = (clr_cnt_ff == IW'(ENTRIES - 1));

   always_comb begin
      slot_we  = 1'b0;
      slot_wa  = clr_cnt_ff;
      slot_wd  = '0;
      stack_we = 1'b0;
      stack_wa = slot_rd_ff;
      stack_wd = '{erased: 1'b0, idx: addr};
      code_we  = 1'b0;
      top_in   = top_ff;
      count_in = count_ff;
      rsp_in   = '0;

      if (cmd.clr_step) begin
         slot_we = 1'b1;
      end

      if (cmd.exec) begin
         unique case (req_ff.mode)
            MODE_INSERT: begin
               if (in_range) begin
                  code_we = 1'b1;
                  if (!valid) begin
                     if (erased_hit) begin
                        // Revive the erased position in place.
                        stack_we = 1'b1;
                        count_in = count_ff + TW'(1);
                     end else if (can_push) begin
                        slot_we  = 1'b1;
                        slot_wa  = addr;
                        slot_wd  = top_ff[IW-1:0];
                        stack_we = 1'b1;
                        stack_wa = top_ff[IW-1:0];
                        top_in   = top_ff + TW'(1);
                        count_in = count_ff + TW'(1);
                     end
                  end
               end
            end
            MODE_REMOVE: begin
               if (valid) begin
                  stack_we        = 1'b1;
                  stack_wd.erased = 1'b1;
                  if (count_ff != '0) begin
                     count_in = count_ff - TW'(1);
                  end
               end
            end
            MODE_CLEAR: begin
               if (count_ff != '0) begin
                  top_in   = '0;
                  count_in = '0;
               end
            end
            MODE_LOOKUP: begin
               rsp_in.found    = valid;
               rsp_in.code_out = valid ? code_rd_ff : '0;
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end

      rsp_in.live_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      if (cmd.rd_slot) begin
         slot_rd_ff <= slot_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (cmd.rd_stack) begin
         stack_rd_ff <= stack_mem[slot_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (code_we) begin
         code_mem[addr] <= req_ff.code_in;
      end
      if (cmd.rd_stack) begin
         code_rd_ff <= code_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff     <= '0;
         count_ff   <= '0;
         clr_cnt_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         top_ff    <= top_in;
         count_ff  <= count_in;
         strobe_ff <= cmd.exec;
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + IW'(1);
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

### rtl/core/lazy_clear_tagged_table.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lazy_clear_tagged_table: table of tagged entries with one-step clear
//
// Operations arrive on the request channel: a transfer happens at a rising
// clock edge where start is high and busy is low. Each operation inserts
// or updates, removes, clears all, or looks up one entry, and produces
// exactly one result on the response channel.
// A result is shown on rsp_data for a single cycle, flagged by rsp_strobe.
// The strobe rises after the slot read, the stack read and the execute
// cycle of the request, and the result is transferred at the first edge
// that sees it high. The receiver has no way to hold it off, so it must
// take every strobe. A new request is taken no sooner than the execute
// cycle of the last one, a bound set by the chain of dependent memory
// accesses in each operation: a slot array read, then an index stack
// read, then the execute cycle that writes back. After reset the slot
// array is swept to zero, one entry a cycle, and busy stays high, so no
// request is taken, until all ENTRIES (1024 at the default) are written.
// Reset also zeroes the stack top and live count. Clear all only rewinds
// the stack top and zeroes the live count, so it costs no more than others.
// ---------------------------------------------------------------------------
module lazy_clear_tagged_table
   import lctt_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // The controller sequences each operation and the post-reset sweep.
   lctt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath owns all storage and forms the registered result.
   lctt_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Every accepted request yields a result strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result strobe missing after an accepted request");

   // Execute cycles never run back to back, so results cannot collide.
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec)
      else $error("two execute cycles in a row");

   // The live count can never exceed the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.live_count <= ENTRIES))
      else $error("live count above table size");

   // The slot sweep keeps the block busy right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("request taken before the slot sweep finished");

endmodule
`default_nettype wire

### tb/lazy_clear_tagged_table_test.sv
// ---------------------------------------------------------------------------
// lazy_clear_tagged_table_test: self-checking bench for the tagged table
// Drives insert, remove, clear-all and look-up commands into the block. A
// shadow copy of the sparse-set table predicts every response, and each
// response is checked field by field against the oldest pending prediction.
// ---------------------------------------------------------------------------
module lazy_clear_tagged_table_test import lctt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES        = DEFAULT_ENTRIES;
   localparam int HALF_PERIOD    = 2;
   localparam int RANDOM_OPS     = 600;
   localparam int FILL_OPS       = 128;
   // The longest legal quiet stretch is the slot sweep after reset.
   // After that it is a sender gap plus the pipeline.
   localparam int WATCHDOG_LIMIT = 4 * ENTRIES + 1000;
   localparam int DRAIN_CYCLES   = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   lazy_clear_tagged_table #(.ENTRIES(ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow table. Each stack cell holds an entry index plus an erased tag.
   // An entry is live when its slot lies below the stack top and the cell
   // at that slot names the entry with the tag clear. Reset contents of the
   // arrays do not matter: every cell below the top was written after the
   // top last moved past it.
   // ------------------------------------------------------------------------
   typedef struct packed {
      logic             erased;
      logic [KEY_W-1:0] key;
   } stack_cell_type;

   logic [KEY_W-1:0]   shadow_slot  [ENTRIES];
   stack_cell_type     shadow_stack [ENTRIES];
   logic [CODE_W-1:0]  shadow_code  [ENTRIES];
   logic [COUNT_W-1:0] shadow_top   = '0;
   logic [COUNT_W-1:0] shadow_live  = '0;

   rsp_type pending_answers [$];
   int      failures = 0;
   int      quiet_cycles = 0;
   bit      idle_on = 1'b1;

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_slot[i]  = '0;
         shadow_stack[i] = '0;
         shadow_code[i]  = '0;
      end
   end

   function automatic bit entry_live(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] s;
      s = shadow_slot[key];
      return (s < shadow_top) && (shadow_stack[s] == {1'b0, key});
   endfunction

   function automatic bit entry_erased(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] s;
      s = shadow_slot[key];
      return (s < shadow_top) && (shadow_stack[s] == {1'b1, key});
   endfunction

   // Applies one command to the shadow table and returns the response the
   // block must give for it.
   function automatic rsp_type apply_table_op(input req_type cmd);
      rsp_type          answer;
      bit               in_range;
      logic [KEY_W-1:0] key;
      answer   = '0;
      key      = cmd.entry_index;
      in_range = int'(key) < ENTRIES;
      case (cmd.mode)
         MODE_INSERT: begin
            if (in_range) begin
               if (!entry_live(key)) begin
                  if (entry_erased(key)) begin
                     // A removed entry gets its old stack cell back.
                     shadow_stack[shadow_slot[key]] = {1'b0, key};
                     shadow_live++;
                  end else if (int'(shadow_top) < ENTRIES) begin
                     shadow_slot[key]        = shadow_top;
                     shadow_stack[shadow_top] = {1'b0, key};
                     shadow_top++;
                     shadow_live++;
                  end
               end
               shadow_code[key] = cmd.code_in;
            end
         end
         MODE_REMOVE: begin
            if (in_range && entry_live(key)) begin
               if (shadow_live != 0) shadow_live--;
               shadow_stack[shadow_slot[key]] = {1'b1, key};
            end
         end
         MODE_CLEAR: begin
            // An empty table keeps its stack top on clear all.
            if (shadow_live != 0) begin
               shadow_live = '0;
               shadow_top  = '0;
            end
         end
         default: begin
            if (in_range && entry_live(key)) begin
               answer.found    = 1'b1;
               answer.code_out = shadow_code[key];
            end
         end
      endcase
      answer.live_count = shadow_live;
      return answer;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------------
   // Transfer monitor and response checker. Both sides are sampled at the
   // rising edge, before the block's own updates of that edge land. The
   // prediction is queued before the strobe is checked, so a response and
   // a new request in the same cycle are handled in a fixed order.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) pending_answers.push_back(apply_table_op(req_data));
         if (rsp_strobe === 1'b1) begin
            if (pending_answers.size() == 0) begin
               note_failure($sformatf("response with nothing pending: %p", rsp_data));
            end else begin
               want = pending_answers.pop_front();
               if (rsp_data.found !== want.found)
                  note_failure($sformatf("found: expected %0d got %0d",
                                         want.found, rsp_data.found));
               if (rsp_data.code_out !== want.code_out)
                  note_failure($sformatf("code_out: expected %0h got %0h",
                                         want.code_out, rsp_data.code_out));
               if (rsp_data.live_count !== want.live_count)
                  note_failure($sformatf("live_count: expected %0d got %0d",
                                         want.live_count, rsp_data.live_count));
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel has a transfer for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[lazy_clear_tagged_table] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sends one command. The sender first idles a random number of cycles,
   // unless idling is switched off, then holds start high until a rising
   // edge sees busy low. Inputs only change at the falling edge, and start
   // is written at most once per falling edge.
   // ------------------------------------------------------------------------
   task automatic send_op(input logic [MODE_W-1:0] mode,
                          input logic [KEY_W-1:0] key,
                          input logic [CODE_W-1:0] code);
      int gap;
      gap = idle_on ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data = '{mode: mode, entry_index: key, code_in: code};
      start    = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Short directed walk through every command and each corner of the
   // scheme: out-of-range indexes, overwrite of a live entry, removal of an
   // absent entry, reuse of an erased stack cell, and clear all both with an
   // empty table (the stack top survives) and with live entries.
   task automatic test_directed();
      send_op(MODE_LOOKUP, 11'd0,    '0);
      send_op(MODE_LOOKUP, 11'd2047, '0);
      send_op(MODE_CLEAR,  11'd0,    '0);
      send_op(MODE_INSERT, 11'd0,    31'h7fff_ffff);
      send_op(MODE_INSERT, 11'd1023, 31'h0);
      send_op(MODE_LOOKUP, 11'd0,    '0);
      send_op(MODE_LOOKUP, 11'd1023, '0);
      send_op(MODE_INSERT, 11'd1024, 31'h5555_5555);
      send_op(MODE_LOOKUP, 11'd1024, '0);
      send_op(MODE_REMOVE, 11'd2047, '0);
      send_op(MODE_INSERT, 11'd0,    31'h1234_5678);
      send_op(MODE_LOOKUP, 11'd0,    '0);
      send_op(MODE_REMOVE, 11'd5,    '0);
      send_op(MODE_REMOVE, 11'd0,    '0);
      send_op(MODE_LOOKUP, 11'd0,    '0);
      send_op(MODE_INSERT, 11'd0,    31'h2aaa_aaaa);
      send_op(MODE_REMOVE, 11'd1023, '0);
      send_op(MODE_REMOVE, 11'd0,    '0);
      send_op(MODE_CLEAR,  11'd0,    '0);
      send_op(MODE_INSERT, 11'd0,    31'h0f0f_0f0f);
      send_op(MODE_LOOKUP, 11'd1023, '0);
      send_op(MODE_CLEAR,  11'd0,    '0);
      send_op(MODE_LOOKUP, 11'd0,    '0);
      send_op(MODE_INSERT, 11'd1023, 31'h4321_8765);
      send_op(MODE_LOOKUP, 11'd1023, '0);
   endtask

   // Inserts a block of entries drawn in shuffled order from the whole
   // table, back to back, then updates, removes and re-inserts some of them.
   task automatic test_bulk_fill();
      int order [ENTRIES];
      int j;
      int tmp;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < ENTRIES; i++) order[i] = i;
      for (int i = ENTRIES - 1; i > 0; i--) begin
         j        = int'($urandom_range(0, i));
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      idle_on = 1'b0;
      for (int i = 0; i < FILL_OPS; i++) begin
         send_op(MODE_INSERT, KEY_W'(order[i]), CODE_W'($urandom));
      end
      idle_on = 1'b1;
      send_op(MODE_INSERT, KEY_W'(order[0]), CODE_W'($urandom));
      for (int i = 0; i < 3; i++) begin
         k = KEY_W'(order[$urandom_range(0, FILL_OPS - 1)]);
         send_op(MODE_REMOVE, k, '0);
         send_op(MODE_LOOKUP, k, '0);
         send_op(MODE_INSERT, k, CODE_W'($urandom));
         send_op(MODE_LOOKUP, k, '0);
      end
      send_op(MODE_CLEAR, 11'd0, '0);
      send_op(MODE_LOOKUP, KEY_W'(order[0]), '0);
   endtask

   // Random commands. Most indexes come from a small set of hot entries so
   // that look-ups hit, removes find live entries and erased cells get
   // reused; the rest spread over the whole table and past its end.
   task automatic test_random();
      int sel;
      logic [KEY_W-1:0]  key;
      logic [MODE_W-1:0] mode;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         // Now and then switch idling off for a stretch of back-to-back
         // transfers.
         if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
         sel = int'($urandom_range(0, 99));
         if (sel < 60) begin
            key = KEY_W'($urandom_range(0, 15));
            if (key >= 8) key = key + KEY_W'(ENTRIES - 16);
         end else if (sel < 85) begin
            key = KEY_W'($urandom_range(0, ENTRIES - 1));
         end else begin
            key = KEY_W'($urandom_range(0, 2047));
         end
         sel = int'($urandom_range(0, 99));
         if (sel < 35)      mode = MODE_INSERT;
         else if (sel < 55) mode = MODE_REMOVE;
         else if (sel < 59) mode = MODE_CLEAR;
         else               mode = MODE_LOOKUP;
         send_op(mode, key, CODE_W'($urandom));
      end
      idle_on = 1'b1;
   endtask

   initial begin
      // Synchronous reset is applied first; the block then sweeps its
      // slot array while busy is high, and the first transfer waits for it.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_bulk_fill();
      test_random();

      @(negedge clock);
      start = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0)
         note_failure($sformatf("%0d responses never arrived", pending_answers.size()));

      if (failures == 0) begin
         $display("[lazy_clear_tagged_table] OK");
      end else begin
         $display("[lazy_clear_tagged_table] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/lctt_pkg.sv
rtl/core/lctt_ctrl.sv
rtl/core/lctt_dpath.sv
rtl/core/lazy_clear_tagged_table.sv
tb/lazy_clear_tagged_table_test.sv
